// File: hw/rtl/uart_pwm_command_parser_core_assert.svh
// Assertion macros shared by the command parser modules.
`ifndef UART_PWM_COMMAND_PARSER_CORE_ASSERT_SVH
`define UART_PWM_COMMAND_PARSER_CORE_ASSERT_SVH

// Check that cond holds in the same cycle whenever trig is seen.
`define UPC_ASSERT_NOW(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("upc assertion failed");

// Check that cond holds in the cycle after trig is seen.
`define UPC_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("upc assertion failed");

`endif

// File: hw/rtl/upc_pkg.sv
// Types, codes and constants of the UART PWM command parser.
package upc_pkg;

	// Reciprocal of one hundred: for any 32-bit x, x / 100 = (x * RECIP_100) >> RECIP_SH
	localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
	localparam int          RECIP_SH  = 37;

	// Steps of the duty divide and width of their counter
	localparam int DIV_STEPS = 5;
	localparam int DIV_CNT_W = 3;

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_BS   = 8'h08;
	localparam logic [7:0] CH_DEL  = 8'h7F;
	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;
	localparam logic [7:0] CH_LC_D = 8'h64;
	localparam logic [7:0] CH_UC_D = 8'h44;
	localparam logic [7:0] CH_LC_P = 8'h70;
	localparam logic [7:0] CH_UC_P = 8'h50;
	localparam logic [7:0] CH_LC_S = 8'h73;
	localparam logic [7:0] CH_UC_S = 8'h53;

	localparam logic [31:0] DUTY_MAX      = 32'd100;
	localparam logic [31:0] DIV_BASE      = 32'd100;
	localparam logic [31:0] RST_PERIOD_US = 32'd1000;
	localparam logic [6:0]  RST_DUTY      = 7'd50;

	typedef enum logic [3:0] {
		EV_NONE        = 4'd0,
		EV_APPLIED     = 4'd1,
		EV_SHOW        = 4'd2,
		EV_HELP        = 4'd3,
		EV_BAD_DUTY    = 4'd4,
		EV_BAD_PERIOD  = 4'd5,
		EV_PERIOD_ZERO = 4'd6,
		EV_DUTY_RANGE  = 4'd7,
		EV_UNKNOWN     = 4'd8,
		EV_TOO_LONG    = 4'd9
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_EVAL,
		ST_MUL1,
		ST_MUL2,
		ST_DIV,
		ST_RESP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic take;
		logic store;
		logic len_dec;
		logic len_clr;
		logic scan_start;
		logic scan_step;
		logic ev_load;
		ev_t  ev;
		logic set_duty;
		logic set_period;
		logic mul1;
		logic mul2;
		logic div_step;
		logic dcnt_load;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_eol;
		logic is_bs;
		logic len_zero;
		logic len_full;
		logic scan_done;
		logic cnt_zero;
		logic first_d;
		logic first_p;
		logic first_s;
		logic digits_valid;
		logic duty_over;
		logic acc_zero;
		logic help_hit;
		logic div_last;
	} sts_t;

	// Letter k of the help keyword, lower or upper case
	function automatic logic [7:0] help_char(input logic [1:0] k, input logic upper);
		logic [7:0] lc;
		unique case (k)
			2'd0: lc = 8'h68;
			2'd1: lc = 8'h65;
			2'd2: lc = 8'h6C;
			default: lc = 8'h70;
		endcase
		return upper ? (lc & 8'hDF) : lc;
	endfunction

endpackage

// File: hw/rtl/upc_ctrl.sv
// Sequencing state machine of the command parser.
`include "uart_pwm_command_parser_core_assert.svh"

module upc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  upc_pkg::sts_t sts,
	output upc_pkg::cmd_t cmd
);

	upc_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	upc_pkg::ev_t    eval_ev;
	logic            eval_duty, eval_period;

	// Decide the command outcome from the scan results
	always_comb begin
		eval_ev     = upc_pkg::EV_UNKNOWN;
		eval_duty   = 1'b0;
		eval_period = 1'b0;
		priority if (sts.cnt_zero) begin
			eval_ev = upc_pkg::EV_NONE;
		end else if (sts.first_d) begin
			priority if (!sts.digits_valid) eval_ev = upc_pkg::EV_BAD_DUTY;
			else if (sts.duty_over) eval_ev = upc_pkg::EV_DUTY_RANGE;
			else begin
				eval_ev   = upc_pkg::EV_APPLIED;
				eval_duty = 1'b1;
			end
		end else if (sts.first_p) begin
			priority if (!sts.digits_valid) eval_ev = upc_pkg::EV_BAD_PERIOD;
			else if (sts.acc_zero) eval_ev = upc_pkg::EV_PERIOD_ZERO;
			else begin
				eval_ev     = upc_pkg::EV_APPLIED;
				eval_period = 1'b1;
			end
		end else if (sts.first_s) begin
			eval_ev = upc_pkg::EV_SHOW;
		end else if (sts.help_hit) begin
			eval_ev = upc_pkg::EV_HELP;
		end else begin
			eval_ev = upc_pkg::EV_UNKNOWN;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			upc_pkg::ST_IDLE:   if (in_valid) state_d = upc_pkg::ST_DECODE;
			upc_pkg::ST_DECODE: begin
				if (sts.is_eol && !sts.len_zero) state_d = upc_pkg::ST_SCAN;
				else state_d = upc_pkg::ST_RESP;
			end
			upc_pkg::ST_SCAN:   if (sts.scan_done) state_d = upc_pkg::ST_EVAL;
			upc_pkg::ST_EVAL: begin
				if (eval_duty || eval_period) state_d = upc_pkg::ST_MUL1;
				else state_d = upc_pkg::ST_RESP;
			end
			upc_pkg::ST_MUL1:   state_d = upc_pkg::ST_MUL2;
			upc_pkg::ST_MUL2:   state_d = upc_pkg::ST_DIV;
			upc_pkg::ST_DIV:    if (sts.div_last) state_d = upc_pkg::ST_RESP;
			upc_pkg::ST_RESP:   if (!out_valid_q || out_ready) state_d = upc_pkg::ST_IDLE;
			default:            state_d = upc_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		cmd.ev = upc_pkg::EV_NONE;
		unique case (state_q)
			upc_pkg::ST_IDLE: cmd.take = in_valid;
			upc_pkg::ST_DECODE: begin
				priority if (sts.is_eol) begin
					cmd.scan_start = !sts.len_zero;
					cmd.ev_load    = sts.len_zero;
				end else if (sts.is_bs) begin
					cmd.len_dec = !sts.len_zero;
					cmd.ev_load = 1'b1;
				end else begin
					cmd.ev_load = 1'b1;
					cmd.store   = !sts.len_full;
					cmd.len_clr = sts.len_full;
					cmd.ev      = sts.len_full ? upc_pkg::EV_TOO_LONG : upc_pkg::EV_NONE;
				end
			end
			upc_pkg::ST_SCAN: cmd.scan_step = 1'b1;
			upc_pkg::ST_EVAL: begin
				cmd.len_clr    = 1'b1;
				cmd.ev_load    = 1'b1;
				cmd.ev         = eval_ev;
				cmd.set_duty   = eval_duty;
				cmd.set_period = eval_period;
			end
			upc_pkg::ST_MUL1: cmd.mul1 = 1'b1;
			upc_pkg::ST_MUL2: cmd.mul2 = 1'b1;
			upc_pkg::ST_DIV: begin
				cmd.div_step  = 1'b1;
				cmd.dcnt_load = sts.div_last;
			end
			upc_pkg::ST_RESP: cmd.out_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	// Hold state and the result-word valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= upc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.out_load | (out_valid_q & ~out_ready);
		end
	end

	assign in_ready  = (state_q == upc_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	`UPC_ASSERT_NOW(a_out_free, clk, arst_n, cmd.out_load, !out_valid_q || out_ready)
	`UPC_ASSERT_NEXT(a_take_decode, clk, arst_n, in_valid && in_ready,
		state_q == upc_pkg::ST_DECODE)
	`UPC_ASSERT_NEXT(a_div_resp, clk, arst_n, state_q == upc_pkg::ST_DIV && sts.div_last,
		state_q == upc_pkg::ST_RESP)

endmodule

// File: hw/rtl/upc_dp.sv
// Datapath: line buffer, command scan, settings and PWM count arithmetic.
`include "uart_pwm_command_parser_core_assert.svh"

module upc_dp #(
	parameter int BUF_SIZE      = 32,
	parameter int COUNTS_PER_US = 100
) (
	input  logic          clk,
	input  logic          arst_n,
	input  upc_pkg::cmd_t cmd,
	output upc_pkg::sts_t sts,
	input  logic [7:0]    rx_byte,
	output logic [3:0]    event_res,
	output logic [31:0]   pwm_period,
	output logic [31:0]   pwm_high,
	output logic [31:0]   period_set_now,
	output logic [6:0]    duty_percent_now
);

	localparam int          ADDR_W   = $clog2(BUF_SIZE);
	localparam logic [31:0] Cpu32    = 32'(COUNTS_PER_US);
	localparam logic [31:0] RstPcnt  = 32'(1000 * COUNTS_PER_US);
	localparam logic [31:0] RstDcnt  = RstPcnt >> 1;
	localparam int          CW       = upc_pkg::DIV_CNT_W;

	logic [7:0]        byte_q;
	logic [ADDR_W-1:0] len_q;
	logic [7:0]        line_buf_q [BUF_SIZE];

	logic [ADDR_W-1:0] scan_idx_q, pos_s1, cnt_q;
	logic              data_vld_s1;
	logic [7:0]        rd_data_s1;
	logic [7:0]        first_q;
	logic              ok_q, hl_q, hu_q;
	logic [31:0]       acc_q;

	logic [31:0]       period_q, pcnt_q, dcnt_q;
	logic [6:0]        duty_q;
	logic [63:0]       prod_q;
	logic [31:0]       quo_q, qd_q;
	logic [6:0]        rem_q;
	logic [13:0]       rd_q;
	logic [6:0]        frac_q;
	logic [CW-1:0]     div_cnt_q;
	upc_pkg::ev_t      ev_q;

	logic [3:0]        ev_out_q;
	logic [31:0]       pcnt_out_q, dcnt_out_q, period_out_q;
	logic [6:0]        duty_out_q;

	logic              rd_en, proc, is_digit, help_pos;
	logic [8:0]        pos_ext, cnt_ext;
	logic [35:0]       acc_x10;
	logic [31:0]       rem_full;
	logic [63:0]       frac_prod;

	// Latch the accepted byte
	always_ff @(posedge clk) begin
		if (cmd.take) byte_q <= rx_byte;
	end

	// Track the line length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.len_clr) begin
			len_q <= '0;
		end else if (cmd.store) begin
			len_q <= len_q + 1'b1;
		end else if (cmd.len_dec) begin
			len_q <= len_q - 1'b1;
		end
	end

	// Line buffer memory: write at the line end, read at the scan pointer
	assign rd_en = cmd.scan_step && (scan_idx_q != len_q);

	always_ff @(posedge clk) begin
		if (cmd.store) line_buf_q[len_q] <= byte_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= line_buf_q[scan_idx_q];
			pos_s1     <= scan_idx_q;
		end
	end

	// Advance the scan pointer and mark returning read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			data_vld_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_idx_q  <= '0;
			data_vld_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			if (rd_en) scan_idx_q <= scan_idx_q + 1'b1;
			data_vld_s1 <= rd_en;
		end
	end

	// Parse each stored character as it comes back
	assign proc     = cmd.scan_step && data_vld_s1 && (rd_data_s1 != upc_pkg::CH_NUL);
	assign is_digit = (rd_data_s1 >= upc_pkg::CH_D0) && (rd_data_s1 <= upc_pkg::CH_D9);
	assign pos_ext  = 9'(pos_s1);
	assign cnt_ext  = 9'(cnt_q);
	assign help_pos = pos_ext < 9'd4;
	assign acc_x10  = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(rd_data_s1[3:0]);

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			cnt_q <= '0;
			ok_q  <= 1'b1;
			hl_q  <= 1'b1;
			hu_q  <= 1'b1;
			acc_q <= '0;
		end else if (proc) begin
			cnt_q <= cnt_q + 1'b1;
			if (pos_s1 == '0) begin
				first_q <= rd_data_s1;
			end else if (!is_digit) begin
				ok_q <= 1'b0;
			end else begin
				acc_q <= (acc_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : acc_x10[31:0];
			end
			if (help_pos) begin
				hl_q <= hl_q && (rd_data_s1 == upc_pkg::help_char(pos_ext[1:0], 1'b0));
				hu_q <= hu_q && (rd_data_s1 == upc_pkg::help_char(pos_ext[1:0], 1'b1));
			end
		end
	end

	// Split the duty product: P*d/100 = (P/100)*d + ((P mod 100)*d)/100,
	// each stage advancing once per divide step
	assign rem_full  = pcnt_q - quo_q * upc_pkg::DIV_BASE;
	assign frac_prod = 64'(rd_q) * 64'(upc_pkg::RECIP_100);

	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			prod_q    <= 64'(pcnt_q) * 64'(upc_pkg::RECIP_100);
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q     <= 32'(prod_q[63:upc_pkg::RECIP_SH]);
			rem_q     <= rem_full[6:0];
			qd_q      <= quo_q * 32'(duty_q);
			rd_q      <= 14'(rem_q) * 14'(duty_q);
			frac_q    <= frac_prod[upc_pkg::RECIP_SH +: 7];
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// Settings and PWM counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= upc_pkg::RST_PERIOD_US;
			duty_q   <= upc_pkg::RST_DUTY;
			pcnt_q   <= RstPcnt;
			dcnt_q   <= RstDcnt;
		end else begin
			if (cmd.set_duty) duty_q <= acc_q[6:0];
			if (cmd.set_period) period_q <= acc_q;
			if (cmd.mul1) pcnt_q <= period_q * Cpu32;
			if (cmd.dcnt_load) dcnt_q <= qd_q + 32'(frac_q);
		end
	end

	// Hold the event code and the result word
	always_ff @(posedge clk) begin
		if (cmd.ev_load) ev_q <= cmd.ev;
		if (cmd.out_load) begin
			ev_out_q     <= ev_q;
			pcnt_out_q   <= pcnt_q;
			dcnt_out_q   <= dcnt_q;
			period_out_q <= period_q;
			duty_out_q   <= duty_q;
		end
	end

	// Status back to the controller
	always_comb begin
		sts.is_eol       = (byte_q == upc_pkg::CH_CR) || (byte_q == upc_pkg::CH_LF);
		sts.is_bs        = (byte_q == upc_pkg::CH_BS) || (byte_q == upc_pkg::CH_DEL);
		sts.len_zero     = (len_q == '0);
		sts.len_full     = (len_q == ADDR_W'(BUF_SIZE - 1));
		sts.scan_done    = (data_vld_s1 && (rd_data_s1 == upc_pkg::CH_NUL))
		                 || (!data_vld_s1 && (scan_idx_q == len_q));
		sts.cnt_zero     = (cnt_q == '0);
		sts.first_d      = (first_q == upc_pkg::CH_LC_D) || (first_q == upc_pkg::CH_UC_D);
		sts.first_p      = (first_q == upc_pkg::CH_LC_P) || (first_q == upc_pkg::CH_UC_P);
		sts.first_s      = (first_q == upc_pkg::CH_LC_S) || (first_q == upc_pkg::CH_UC_S);
		sts.digits_valid = ok_q && (cnt_ext >= 9'd2);
		sts.duty_over    = acc_q > upc_pkg::DUTY_MAX;
		sts.acc_zero     = (acc_q == '0);
		sts.help_hit     = (cnt_ext == 9'd4) && (hl_q || hu_q);
		sts.div_last     = (div_cnt_q == CW'(upc_pkg::DIV_STEPS - 1));
	end

	assign event_res        = ev_out_q;
	assign pwm_period       = pcnt_out_q;
	assign pwm_high         = dcnt_out_q;
	assign period_set_now   = period_out_q;
	assign duty_percent_now = duty_out_q;

	`UPC_ASSERT_NOW(a_duty_range, clk, arst_n, 1'b1, 32'(duty_q) <= upc_pkg::DUTY_MAX)
	`UPC_ASSERT_NOW(a_period_nonzero, clk, arst_n, 1'b1, period_q != '0)
	`UPC_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1, 32'(len_q) <= 32'(BUF_SIZE - 1))

endmodule

// File: hw/rtl/uart_pwm_command_parser_core.sv
// Top level of the UART PWM command parser: controller plus datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | rx_byte
//   out     | out_valid/ out_ready | event_res, pwm_period, pwm_high,
//           |                      | period_set_now, duty_percent_now
//
// One word in gives one word out. An ordinary byte, backspace or empty line end
// goes from the decode state straight to the response state. A line end with
// characters first scans the line buffer, one read per cycle, up to the first
// zero byte or the line end; a setting that is applied then passes through the
// period multiply, the reciprocal multiply and the 5-step divide by one hundred.
// in_ready is high only while the sequencer is idle, from the cycle the result
// appears; a result waiting on out_ready holds the sequencer in its last state,
// and one finished result may wait in the output register while the next byte
// is accepted. arst_n loads the default settings.
module uart_pwm_command_parser_core #(
	parameter int BUF_SIZE      = 32,
	parameter int COUNTS_PER_US = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_res,
	output logic [31:0] pwm_period,
	output logic [31:0] pwm_high,
	output logic [31:0] period_set_now,
	output logic [6:0]  duty_percent_now
);

	upc_pkg::cmd_t cmd;
	upc_pkg::sts_t sts;

	// Sequencer
	upc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Line buffer and arithmetic
	upc_dp #(
		.BUF_SIZE      (BUF_SIZE),
		.COUNTS_PER_US (COUNTS_PER_US)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.rx_byte          (rx_byte),
		.event_res        (event_res),
		.pwm_period       (pwm_period),
		.pwm_high         (pwm_high),
		.period_set_now   (period_set_now),
		.duty_percent_now (duty_percent_now)
	);

endmodule
